### hdl/blcm_pkg.sv
// Shared types and constants for the battery low-charge monitor.
`timescale 1ns / 1ps

package blcm_pkg;

   // item opcodes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_LEVEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_LEVEL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SLOPE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STARTUP_LOW  = 3'd7;
   localparam int CSR_DATA_W = 17;

   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
   localparam int RECENT_NEEDED = 4;

   // datapath widths; ages stay below 1023 minutes, i.e. under 2^26 ms
   localparam int TIME_W = 32;
   localparam int AGE_W  = 26;
   localparam int SX_W   = 28;
   localparam int SY_W   = 18;
   localparam int DEN_W  = 56;
   localparam int NUM_W  = 48;
   localparam int OPND_W = 33;
   localparam int PROD_W = 2 * OPND_W;
   localparam int ACC_W  = 76;

   typedef enum logic [1:0] {
      SH_NONE = 2'd0,
      SH_X4   = 2'd1,
      SH_24   = 2'd2,
      SH_28   = 2'd3
   } shift_sel_type;

   typedef struct packed {
      logic          valid;
      logic          sub;
      shift_sel_type shift;
   } mac_ctl_type;

endpackage

### hdl/blcm_mac.sv
// Shared signed multiply-accumulate unit: registered product, then shifted add/subtract.
`timescale 1ns / 1ps

module blcm_mac import blcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  mac_ctl_type              issue,
   input  logic signed [OPND_W-1:0] op_a,
   input  logic signed [OPND_W-1:0] op_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff;
   mac_ctl_type              ctl_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  ext;
   logic signed [ACC_W-1:0]  shifted;

   always_comb begin
      ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      case (ctl_ff.shift)
         SH_NONE: shifted = ext;
         SH_X4:   shifted = ext <<< 2;
         SH_24:   shifted = ext <<< 24;
         SH_28:   shifted = ext <<< 28;
         default: shifted = ext;
      endcase
      acc_in = ctl_ff.sub ? (acc_ff - shifted) : (acc_ff + shifted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= issue;
      end
      prod_ff <= op_a * op_b;
      if (clear) begin
         acc_ff <= '0;
      end else if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

### hdl/battery_low_charge_monitor_top.sv
// Top level of the battery low-charge monitor.
`timescale 1ns / 1ps

// Battery low-charge monitor.
// req channel: one word per item, opcode add (voltage + timestamp) or check.
// rsp channel: exactly one word per request word, in order.
// csr port: plain write port; write it only while the block is idle (the block itself does not enforce this).
// Add: a voltage at/above full level empties the history; a voltage below
//   low level past warm-up goes into a HISTORY_DEPTH deep ring of
//   voltage/time.
// Check: the newest up to four entries are aged against now; recent ones are
//   counted. With four recent, lead-acid mode tests their sum against 4x the
//   limit, lithium mode tests the least-squares slope (mV/hour) against the
//   minimum without any division: num*3600000 >= min_slope*den.
//   Gather walks one history entry per cycle; the slope test makes 14
//   passes through the one shared 33x33 multiply-accumulate unit, with a
//   pipeline drain after each of den, num and diff.
// The block takes one word at a time; req_stall is high while it works.
// The result sits in an output register, so a new word is taken while a
// result waits on rsp_stall; the next result then waits until it drains.
// Reset (synchronous) empties the history and loads the register defaults.

module battery_low_charge_monitor_top import blcm_pkg::*; #(
   parameter int HISTORY_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [15:0]           req_voltage_mv,
   input  logic [TIME_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_charge_ok,
   output logic [2:0]            rsp_recent_count,
   output logic                  rsp_sample_stored,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(HISTORY_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_GATHER, S_DECIDE,
      S_DEN_MUL, S_DEN_WAIT, S_DEN_TAKE,
      S_NUM_MUL, S_NUM_WAIT, S_NUM_TAKE,
      S_DIFF_MUL, S_DIFF_WAIT, S_DIFF_TAKE,
      S_DONE
   } state_type;

   // configuration registers
   logic [15:0]        full_level_ff;
   logic [15:0]        low_level_ff;
   logic               lead_mode_ff;
   logic [15:0]        lead_limit_ff;
   logic signed [16:0] min_slope_ff;
   logic [9:0]         warmup_ff;
   logic [9:0]         window_ff;
   logic               startup_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_level_ff  <= 16'd12600;
         low_level_ff   <= 16'd11100;
         lead_mode_ff   <= 1'b0;
         lead_limit_ff  <= 16'd11200;
         min_slope_ff   <= -17'sd100;
         warmup_ff      <= 10'd5;
         window_ff      <= 10'd10;
         startup_low_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FULL_LEVEL:  full_level_ff  <= csr_wr_data[15:0];
            REG_LOW_LEVEL:   low_level_ff   <= csr_wr_data[15:0];
            REG_LEAD_MODE:   lead_mode_ff   <= csr_wr_data[0];
            REG_LEAD_LIMIT:  lead_limit_ff  <= csr_wr_data[15:0];
            REG_MIN_SLOPE:   min_slope_ff   <= $signed(csr_wr_data);
            REG_WARMUP:      warmup_ff      <= csr_wr_data[9:0];
            REG_WINDOW:      window_ff      <= csr_wr_data[9:0];
            REG_STARTUP_LOW: startup_low_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // history ring
   logic [15:0]       volt_mem [HISTORY_DEPTH];
   logic [TIME_W-1:0] time_mem [HISTORY_DEPTH];
   logic [CW-1:0]     stored_count_ff;
   logic [SW-1:0]     write_slot_ff;

   // item and working registers
   state_type         state_ff;
   logic [15:0]       volt_ff;
   logic [TIME_W-1:0] now_ff;
   logic [AGE_W-1:0]  limit_ff;
   logic [SW-1:0]     rd_slot_ff;
   logic [15:0]       ent_volt_ff;
   logic [TIME_W-1:0] ent_time_ff;
   logic [2:0]        idx_ff;
   logic [2:0]        look_ff;
   logic [2:0]        n_ff;
   logic [2:0]        k_ff;
   logic [AGE_W-1:0]  age_ff [RECENT_NEEDED];
   logic [15:0]       rvolt_ff [RECENT_NEEDED];
   logic [SX_W-1:0]   sx_ff;
   logic [SY_W-1:0]   sy_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [NUM_W-1:0]  num_ff;
   logic              res_ok_ff;
   logic              res_stored_ff;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [2:0]        rsp_count_ff;
   logic              rsp_stored_ff;

   // add-path decisions
   logic [AGE_W-1:0]  warm_ms;
   logic [AGE_W-1:0]  window_ms;
   logic              is_full;
   logic              is_low;
   logic [SW-1:0]     put_slot;
   logic [CW-1:0]     base_count;

   assign warm_ms   = {{(AGE_W-10){1'b0}}, warmup_ff} * {{(AGE_W-16){1'b0}}, MS_PER_MINUTE};
   assign window_ms = {{(AGE_W-10){1'b0}}, window_ff} * {{(AGE_W-16){1'b0}}, MS_PER_MINUTE};
   assign is_full    = (volt_ff >= full_level_ff);
   assign is_low     = (volt_ff < low_level_ff) &&
                       (now_ff >= {{(TIME_W-AGE_W){1'b0}}, warm_ms});
   assign put_slot   = is_full ? '0 : write_slot_ff;
   assign base_count = is_full ? '0 : stored_count_ff;

   // gather path: entry fetched last cycle, aged against now
   logic [SW-1:0]     newest_slot;
   logic [TIME_W-1:0] age_full;
   logic              is_recent;

   assign newest_slot = (write_slot_ff == '0) ? LAST_SLOT : write_slot_ff - 1'b1;
   assign age_full  = now_ff - ent_time_ff;
   assign is_recent = (age_full < {{(TIME_W-AGE_W){1'b0}}, limit_ff});

   // shared MAC operand selection
   logic                     mac_clear;
   mac_ctl_type              mac_issue;
   logic signed [OPND_W-1:0] mac_a;
   logic signed [OPND_W-1:0] mac_b;
   logic signed [ACC_W-1:0]  mac_acc;
   logic signed [OPND_W-1:0] age_op;
   logic signed [OPND_W-1:0] volt_op;
   logic signed [OPND_W-1:0] sx_op;
   logic signed [OPND_W-1:0] sy_op;
   logic signed [OPND_W-1:0] slope_op;

   assign age_op   = $signed({{(OPND_W-AGE_W){1'b0}}, age_ff[k_ff[1:0]]});
   assign volt_op  = $signed({{(OPND_W-16){1'b0}}, rvolt_ff[k_ff[1:0]]});
   assign sx_op    = $signed({{(OPND_W-SX_W){1'b0}}, sx_ff});
   assign sy_op    = $signed({{(OPND_W-SY_W){1'b0}}, sy_ff});
   assign slope_op = {{(OPND_W-17){min_slope_ff[16]}}, min_slope_ff};

   always_comb begin
      mac_clear = 1'b0;
      mac_issue = '0;
      mac_a     = '0;
      mac_b     = '0;
      case (state_ff)
         S_DECIDE, S_DEN_TAKE, S_NUM_TAKE: begin
            mac_clear = 1'b1;
         end
         S_DEN_MUL: begin
            // den = 4*sum(age^2) - sx^2
            mac_issue.valid = 1'b1;
            if (k_ff < 3'd4) begin
               mac_a = age_op;
               mac_b = age_op;
               mac_issue.shift = SH_X4;
            end else begin
               mac_a = sx_op;
               mac_b = sx_op;
               mac_issue.sub = 1'b1;
               mac_issue.shift = SH_NONE;
            end
         end
         S_NUM_MUL: begin
            // num = sx*sy - 4*sum(age*volt)
            mac_issue.valid = 1'b1;
            if (k_ff < 3'd4) begin
               mac_a = age_op;
               mac_b = volt_op;
               mac_issue.sub = 1'b1;
               mac_issue.shift = SH_X4;
            end else begin
               mac_a = sx_op;
               mac_b = sy_op;
               mac_issue.shift = SH_NONE;
            end
         end
         S_DIFF_MUL: begin
            // diff = num*3600000 - min_slope*den, in 24/28-bit halves
            mac_issue.valid = 1'b1;
            case (k_ff[1:0])
               2'd0: begin
                  mac_a = $signed({{(OPND_W-24){1'b0}}, num_ff[23:0]});
                  mac_b = $signed({{(OPND_W-22){1'b0}}, MS_PER_HOUR});
                  mac_issue.shift = SH_NONE;
               end
               2'd1: begin
                  mac_a = {{(OPND_W-24){num_ff[NUM_W-1]}}, num_ff[NUM_W-1:24]};
                  mac_b = $signed({{(OPND_W-22){1'b0}}, MS_PER_HOUR});
                  mac_issue.shift = SH_24;
               end
               2'd2: begin
                  mac_a = slope_op;
                  mac_b = $signed({{(OPND_W-28){1'b0}}, den_ff[27:0]});
                  mac_issue.sub = 1'b1;
                  mac_issue.shift = SH_NONE;
               end
               default: begin
                  mac_a = slope_op;
                  mac_b = $signed({{(OPND_W-28){1'b0}}, den_ff[DEN_W-1:28]});
                  mac_issue.sub = 1'b1;
                  mac_issue.shift = SH_28;
               end
            endcase
         end
         default: ;
      endcase
   end

   blcm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .clear (mac_clear),
      .issue (mac_issue),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   // sequencer, history and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         stored_count_ff <= '0;
         write_slot_ff   <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  volt_ff       <= req_voltage_mv;
                  now_ff        <= req_now_ms;
                  limit_ff      <= window_ms;
                  idx_ff        <= '0;
                  n_ff          <= '0;
                  k_ff          <= '0;
                  sx_ff         <= '0;
                  sy_ff         <= '0;
                  res_ok_ff     <= 1'b0;
                  res_stored_ff <= 1'b0;
                  // prefetch the newest entry, point at the one before it
                  ent_volt_ff   <= volt_mem[newest_slot];
                  ent_time_ff   <= time_mem[newest_slot];
                  rd_slot_ff    <= (newest_slot == '0) ? LAST_SLOT : newest_slot - 1'b1;
                  if (32'(stored_count_ff) < RECENT_NEEDED) begin
                     look_ff <= 3'(stored_count_ff);
                  end else begin
                     look_ff <= 3'(RECENT_NEEDED);
                  end
                  state_ff <= (req_opcode == OP_ADD) ? S_ADD : S_GATHER;
               end
            end
            S_ADD: begin
               if (is_low) begin
                  volt_mem[put_slot] <= volt_ff;
                  time_mem[put_slot] <= now_ff;
                  write_slot_ff      <= (put_slot == LAST_SLOT) ? '0 : put_slot + 1'b1;
                  stored_count_ff    <= (base_count < FULL_COUNT) ? base_count + 1'b1 :
                                        base_count;
                  res_stored_ff      <= 1'b1;
               end else if (is_full) begin
                  stored_count_ff <= '0;
                  write_slot_ff   <= '0;
               end
               state_ff <= S_DONE;
            end
            S_GATHER: begin
               if (idx_ff == look_ff) begin
                  state_ff <= S_DECIDE;
               end else begin
                  if (is_recent) begin
                     age_ff[n_ff[1:0]]   <= age_full[AGE_W-1:0];
                     rvolt_ff[n_ff[1:0]] <= ent_volt_ff;
                     n_ff  <= n_ff + 1'b1;
                     sx_ff <= sx_ff + {{(SX_W-AGE_W){1'b0}}, age_full[AGE_W-1:0]};
                     sy_ff <= sy_ff + {{(SY_W-16){1'b0}}, ent_volt_ff};
                  end
                  ent_volt_ff <= volt_mem[rd_slot_ff];
                  ent_time_ff <= time_mem[rd_slot_ff];
                  idx_ff      <= idx_ff + 1'b1;
                  rd_slot_ff  <= (rd_slot_ff == '0) ? LAST_SLOT : rd_slot_ff - 1'b1;
               end
            end
            S_DECIDE: begin
               k_ff <= '0;
               if (startup_low_ff) begin
                  res_ok_ff <= 1'b0;
                  state_ff  <= S_DONE;
               end else if (32'(n_ff) < RECENT_NEEDED) begin
                  res_ok_ff <= 1'b1;
                  state_ff  <= S_DONE;
               end else if (lead_mode_ff) begin
                  res_ok_ff <= (sy_ff > {lead_limit_ff, 2'b00});
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_DEN_MUL;
               end
            end
            S_DEN_MUL: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd4) begin
                  state_ff <= S_DEN_WAIT;
               end
            end
            S_DEN_WAIT: begin
               state_ff <= S_DEN_TAKE;
            end
            S_DEN_TAKE: begin
               den_ff <= mac_acc[DEN_W-1:0];
               k_ff   <= '0;
               // all ages equal: no slope, charge counts as OK
               if (mac_acc[DEN_W-1:0] == '0) begin
                  res_ok_ff <= 1'b1;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_NUM_MUL;
               end
            end
            S_NUM_MUL: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd4) begin
                  state_ff <= S_NUM_WAIT;
               end
            end
            S_NUM_WAIT: begin
               state_ff <= S_NUM_TAKE;
            end
            S_NUM_TAKE: begin
               num_ff   <= mac_acc[NUM_W-1:0];
               k_ff     <= '0;
               state_ff <= S_DIFF_MUL;
            end
            S_DIFF_MUL: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == 3'd3) begin
                  state_ff <= S_DIFF_WAIT;
               end
            end
            S_DIFF_WAIT: begin
               state_ff <= S_DIFF_TAKE;
            end
            S_DIFF_TAKE: begin
               res_ok_ff <= ~mac_acc[ACC_W-1];
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ok_ff     <= res_ok_ff;
                  rsp_count_ff  <= n_ff;
                  rsp_stored_ff <= res_stored_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_charge_ok     = rsp_ok_ff;
   assign rsp_recent_count  = rsp_count_ff;
   assign rsp_sample_stored = rsp_stored_ff;

endmodule
